FILE: rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants for the five-segment averager
// Widths, the remainder-to-segment table and the divider handshake structs.
// ----------------------------------------------------------------------------
package fsa_pkg;

   localparam int MAX_FRAMES_DEF = 128;
   localparam int NUM_SEG        = 5;
   localparam int SAMPLE_W       = 16;
   localparam int SEG_W          = 3;
   localparam int COUNT_W        = 8;
   localparam int ITER_W         = $clog2(SAMPLE_W);

   localparam logic [COUNT_W-1:0] FRAME_RESET = COUNT_W'(NUM_SEG);
   localparam logic [SEG_W-1:0]   SEG_FIRST   = '0;
   localparam logic [SEG_W-1:0]   SEG_LAST    = SEG_W'(NUM_SEG - 1);
   localparam logic [SEG_W-1:0]   SEG_END     = SEG_W'(NUM_SEG);

   // floor(c / 5) == (c * 205) >> 10 for every 8-bit c
   localparam logic [COUNT_W-1:0] RECIP_5     = 8'd205;
   localparam int                 RECIP_SHIFT = 10;
   localparam int                 QUOT_W      = 2 * COUNT_W - RECIP_SHIFT;

   // bit k set: segment k takes one extra sample, indexed by count % 5
   localparam logic [NUM_SEG-1:0] EXTRA_MASK [NUM_SEG] = '{
      5'h00, 5'h01, 5'h11, 5'h15, 5'h17
   };

   typedef struct packed {
      logic start;   // load operands and begin
      logic ack;     // quotient taken, return to idle
   } div_ctrl_type;

   typedef struct packed {
      logic done;    // quotient valid, held until ack
   } div_stat_type;

   // Does segment seg get one of the remainder samples?
   function automatic logic has_extra(input logic [SEG_W-1:0] rem,
                                      input logic [SEG_W-1:0] seg);
      logic [NUM_SEG-1:0] mask;
      mask = (rem < SEG_W'(NUM_SEG)) ? EXTRA_MASK[rem] : '0;
      return (seg < SEG_W'(NUM_SEG)) ? mask[seg] : 1'b0;
   endfunction

endpackage

FILE: rtl/fsa_div.sv
// ----------------------------------------------------------------------------
// fsa_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module fsa_div import fsa_pkg::*; #(
   parameter int LEN_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  div_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] dividend,
   input  logic [LEN_W-1:0]           divisor,
   output div_stat_type               stat,
   output logic signed [SAMPLE_W-1:0] quotient
);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} state_type;

   state_type               state_ff, state_in;
   logic [SAMPLE_W-1:0]     quo_ff, quo_in;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [LEN_W-1:0]        div_ff, div_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic                    neg_ff, neg_in;

   logic [LEN_W:0]          trial;
   logic [LEN_W:0]          diff;
   logic                    ge;

   // one restoring step
   assign trial = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      iter_in  = iter_ff;
      neg_in   = neg_ff;
      case (state_ff)
         D_IDLE: begin
            if (ctrl.start) begin
               neg_in   = dividend[SAMPLE_W-1];
               quo_in   = dividend[SAMPLE_W-1] ? SAMPLE_W'(-dividend) : SAMPLE_W'(dividend);
               rem_in   = '0;
               div_in   = divisor;
               iter_in  = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            quo_in  = {quo_ff[SAMPLE_W-2:0], ge};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SAMPLE_W - 1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            if (ctrl.ack) begin
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      iter_ff <= iter_in;
      neg_ff  <= neg_in;
   end

   assign stat.done = (state_ff == D_DONE);
   assign quotient  = neg_ff ? SAMPLE_W'(-quo_ff) : quo_ff;

endmodule

FILE: rtl/five_segment_average.sv
// ----------------------------------------------------------------------------
// five_segment_average: truncated mean over five segments of a sample run
// Sums samples per segment and divides each finished sum by its length.
// ----------------------------------------------------------------------------
// A run of csr_wr_data samples (clamped to 5..MAX_FRAMES) is split into five
// segments of count/5 samples, the remainder adding one sample to segments
// {0}, {0,4}, {0,2,4} or {0,1,2,4}. A sample that does not finish a segment
// is added to the segment sum. A sample that finishes one starts the shared
// bit-serial divider, which loads its operands, steps through the quotient
// bits and hands off the result, with req_ready low throughout; the handoff
// waits while the previous result is still held in the output register, and
// the quotient then moves into that register. The fifth result carries
// rsp_last_segment; later samples are taken and dropped until the next csr
// write, which also restarts the run.
module five_segment_average import fsa_pkg::*; #(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic [SEG_W-1:0]           rsp_segment_index,
   output logic                       rsp_last_segment,
   input  logic                       csr_wr_en,
   input  logic [COUNT_W-1:0]         csr_wr_data
);

   localparam int               LEN_W = $clog2(MAX_FRAMES / NUM_SEG + 2);
   localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_FRAMES);

   typedef enum logic {S_TAKE, S_DIV} state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [SAMPLE_W-1:0]       sum_ff, sum_in;
   logic [LEN_W-1:0]          fill_ff, fill_in;
   logic [SEG_W-1:0]          seg_ff, seg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [SEG_W-1:0]          rsp_seg_ff, rsp_seg_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic signed [SAMPLE_W-1:0] div_num_ff, div_num_in;

   logic [COUNT_W-1:0]        eff_count;
   logic [2*COUNT_W-1:0]      recip_prod;
   logic [QUOT_W-1:0]         base_len;
   logic [SEG_W-1:0]          rem5;
   logic [LEN_W-1:0]          seg_len;
   logic [SAMPLE_W-1:0]       sum_next;
   logic [LEN_W-1:0]          fill_next;
   logic                      req_xfer;
   logic                      out_free;

   div_ctrl_type              div_ctrl;
   div_stat_type              div_stat;
   logic signed [SAMPLE_W-1:0] div_quo;

   // segment length from the clamped run count
   always_comb begin
      eff_count = count_ff;
      if (eff_count < COUNT_W'(NUM_SEG)) begin
         eff_count = COUNT_W'(NUM_SEG);
      end
      if (eff_count > MAX_C) begin
         eff_count = MAX_C;
      end
      recip_prod = {{COUNT_W{1'b0}}, eff_count} * {{COUNT_W{1'b0}}, RECIP_5};
      base_len   = recip_prod[2*COUNT_W-1:RECIP_SHIFT];
      rem5       = SEG_W'(eff_count - COUNT_W'(base_len) * COUNT_W'(NUM_SEG));
      seg_len    = LEN_W'(base_len) + LEN_W'(has_extra(rem5, seg_ff));
   end

   assign req_ready = (state_ff == S_TAKE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sum_next  = sum_ff + req_sample;
   assign fill_next = fill_ff + 1'b1;

   // divider handshake
   always_comb begin
      div_ctrl.start = (state_ff == S_DIV) && !div_stat.done;
      div_ctrl.ack   = (state_ff == S_DIV) && div_stat.done && out_free;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      seg_in       = seg_ff;
      div_num_in   = div_num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_TAKE: begin
            if (req_xfer && seg_ff != SEG_END) begin
               if (fill_next >= seg_len) begin
                  div_num_in = sum_next;
                  sum_in     = '0;
                  fill_in    = '0;
                  state_in   = S_DIV;
               end else begin
                  sum_in  = sum_next;
                  fill_in = fill_next;
               end
            end
         end
         S_DIV: begin
            if (div_ctrl.ack) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = div_quo;
               rsp_seg_in   = seg_ff;
               rsp_last_in  = (seg_ff == SEG_LAST);
               seg_in       = seg_ff + 1'b1;
               state_in     = S_TAKE;
            end
         end
         default: begin
            state_in = S_TAKE;
         end
      endcase
      // register write restarts the run
      if (csr_wr_en) begin
         count_in = csr_wr_data;
         sum_in   = '0;
         fill_in  = '0;
         seg_in   = SEG_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         count_ff     <= FRAME_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         seg_ff       <= SEG_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_num_ff  <= div_num_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_last_ff <= rsp_last_in;
   end

   fsa_div #(
      .LEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_num_ff),
      .divisor  (seg_len),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average       = rsp_avg_ff;
   assign rsp_segment_index = rsp_seg_ff;
   assign rsp_last_segment  = rsp_last_ff;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for five_segment_average
// Feeds sample runs over several frame counts, mostly while both sides stall
// at random, predicts each segment mean and checks every result as it arrives.
// ----------------------------------------------------------------------------

import fsa_pkg::*;

typedef struct {
   logic signed [SAMPLE_W-1:0] average;
   logic [SEG_W-1:0]           segment_index;
   logic                       last_segment;
} segment_mean_type;

// Tracks the run in progress and holds the segment means still to arrive
class average_scoreboard;
   logic [COUNT_W-1:0]  frame_count;
   logic [SAMPLE_W-1:0] seg_sum;
   int unsigned         seg_taken;
   logic [SEG_W-1:0]    seg_id;
   segment_mean_type    expected_means[$];
   int                  errors;

   function new();
      errors = 0;
      set_frame_count(FRAME_RESET);
   endfunction

   // A frame count write restarts the run
   function void set_frame_count(input logic [COUNT_W-1:0] value);
      frame_count = value;
      seg_sum     = '0;
      seg_taken   = 0;
      seg_id      = SEG_FIRST;
   endfunction

   function int unsigned pending();
      return expected_means.size();
   endfunction

   // Samples in segment s: count/5, plus one where the remainder lands on s
   function int unsigned segment_length(input logic [SEG_W-1:0] s);
      int unsigned c;
      int unsigned len;
      bit          extra;
      c = frame_count;
      if (c < NUM_SEG) c = NUM_SEG;
      if (c > MAX_FRAMES_DEF) c = MAX_FRAMES_DEF;
      len = c / NUM_SEG;
      case (c % NUM_SEG)
         1: extra = (s == 0);
         2: extra = (s == 0) || (s == 4);
         3: extra = (s == 0) || (s == 2) || (s == 4);
         4: extra = (s == 0) || (s == 1) || (s == 2) || (s == 4);
         default: extra = 1'b0;
      endcase
      return extra ? len + 1 : len;
   endfunction

   // Account for one accepted sample; returns 0 when the run is already over
   function bit note_sample(input logic [SAMPLE_W-1:0] value);
      int unsigned      len;
      int               sum_s;
      int               quot;
      segment_mean_type m;
      if (seg_id >= SEG_END) return 1'b0;
      seg_sum   = seg_sum + value;
      seg_taken = seg_taken + 1;
      len = segment_length(seg_id);
      if (seg_taken >= len) begin
         sum_s = $signed(seg_sum);
         // int division truncates toward zero
         quot = sum_s / int'(len);
         m.average       = quot[SAMPLE_W-1:0];
         m.segment_index = seg_id;
         m.last_segment  = (seg_id == SEG_LAST);
         expected_means.push_back(m);
         seg_id    = seg_id + 1'b1;
         seg_sum   = '0;
         seg_taken = 0;
      end
      return 1'b1;
   endfunction

   // Compare one result transfer with the oldest expected mean
   function void check_result(input logic [SAMPLE_W-1:0] average,
                              input logic [SEG_W-1:0] segment_index,
                              input logic last_segment);
      segment_mean_type m;
      if (expected_means.size() == 0) begin
         $error("unexpected result: average %0d segment %0d",
                $signed(average), segment_index);
         errors++;
         return;
      end
      m = expected_means.pop_front();
      if (average !== m.average) begin
         $error("average: expected %0d, actual %0d", m.average, $signed(average));
         errors++;
      end
      if (segment_index !== m.segment_index) begin
         $error("segment_index: expected %0d, actual %0d", m.segment_index,
                segment_index);
         errors++;
      end
      if (last_segment !== m.last_segment) begin
         $error("last_segment: expected %0d, actual %0d", m.last_segment,
                last_segment);
         errors++;
      end
   endfunction
endclass

module tb_top;

   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 40;
   localparam int TARGET_ITEMS = 400;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic [SEG_W-1:0]           rsp_segment_index;
   logic                       rsp_last_segment;
   logic                       csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]         csr_wr_data = '0;

   average_scoreboard sb;
   int sender_idle_pct = 9;
   int rsp_idle_pct    = 46;
   int run_samples     = 0;
   int stall_cycles    = 0;

   five_segment_average uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average       (rsp_average),
      .rsp_segment_index (rsp_segment_index),
      .rsp_last_segment  (rsp_last_segment),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Result side: check each transfer, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_average, rsp_segment_index, rsp_last_segment);
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // One sample transfer, with random idle cycles ahead of it
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      if (sb.note_sample(value)) run_samples++;
   endtask

   task automatic write_frame_count(input logic [COUNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_frame_count(value);
   endtask

   // Drain: all means in, then room for a divide started by a trailing sample
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Mostly random, with the extremes mixed in
   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      int phase;
      int count;
      int run_len;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset count of 5: one sample per segment, then two past the run
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'h1234);
      send_sample(16'h8000);
      drain_block();

      // Count 9 (lengths 2,2,2,1,2): wrapped sums and truncation toward zero
      write_frame_count(8'd9);
      send_sample(16'h7FFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      send_sample(16'h8001);
      send_sample(16'hFFFD);
      send_sample(16'h0000);
      drain_block();

      // Random runs: full runs with trailing noise, some cut short
      phase = 0;
      while (run_samples < TARGET_ITEMS) begin
         if (run_samples < TARGET_ITEMS / 3) begin
            sender_idle_pct = 9;
            rsp_idle_pct   <= 46;
         end else if (run_samples < 2 * TARGET_ITEMS / 3) begin
            sender_idle_pct = 46;
            rsp_idle_pct   <= 9;
         end else begin
            sender_idle_pct = 0;
            rsp_idle_pct   <= 0;
         end
         if (phase == 0)
            count = MAX_FRAMES_DEF;
         else if (phase == 1)
            count = NUM_SEG;
         else if ($urandom_range(0, 5) == 0)
            count = $urandom_range(NUM_SEG, MAX_FRAMES_DEF);
         else
            count = $urandom_range(NUM_SEG, 24);
         write_frame_count(COUNT_W'(count));
         if ($urandom_range(0, 4) == 0)
            run_len = $urandom_range(1, count - 1);
         else
            run_len = count + $urandom_range(0, 3);
         repeat (run_len) send_sample(draw_sample());
         drain_block();
         phase++;
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: five_segment_average.f
rtl/fsa_pkg.sv
rtl/fsa_div.sv
rtl/five_segment_average.sv
sim/tb_top.sv
